[rtl/udp_hb_pkg.sv]
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder package
// Types, register indexes and header constants used across the block.
// ----------------------------------------------------------------------------
package udp_hb_pkg;

  localparam int HW_COUNT   = 21;
  localparam int IDX_W      = 5;
  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(HW_COUNT - 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_IP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_PORT   = 3'd5;

  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [15:0] IP_VER_IHL_TOS   = 16'h4500;  // version 4, IHL 5, TOS 0
  localparam logic [15:0] IP_TTL_PROTO     = 16'h4011;  // TTL 64, protocol UDP
  localparam logic [15:0] IP_UDP_HDR_BYTES = 16'd28;
  localparam logic [15:0] UDP_HDR_BYTES    = 16'd8;

  // Width of the un-folded IPv4 header sum (seven 16-bit terms).
  localparam int SUM_W = 19;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

  // Per-request fields that differ from one header to the next.
  typedef struct packed {
    logic [15:0] ip_length;
    logic [15:0] udp_length;
    logic [15:0] checksum;
  } hdr_info_t;

endpackage

[rtl/udp_hb_front.sv]
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder front end
// Accepts requests, forms the length fields and the IPv4 header checksum.
// ----------------------------------------------------------------------------
module udp_hb_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               payload_length,
  input  logic [udp_hb_pkg::SUM_W-1:0] cfg_sum,
  output logic                      push_valid,
  input  logic                      push_ready,
  output udp_hb_pkg::hdr_info_t     push_data
);

  logic                         v1;
  logic [15:0]                  ip_len1;
  logic [15:0]                  udp_len1;
  logic                         v2;
  logic [15:0]                  ip_len2;
  logic [15:0]                  udp_len2;
  logic [udp_hb_pkg::SUM_W-1:0] sum2;
  logic                         en1;
  logic                         en2;
  logic [16:0]                  fold1;
  logic [15:0]                  fold2;

  assign en2      = !v2 || push_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  // Lengths wrap at 16 bits, as the header fields do.
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      ip_len1  <= payload_length + udp_hb_pkg::IP_UDP_HDR_BYTES;
      udp_len1 <= payload_length + udp_hb_pkg::UDP_HDR_BYTES;
    end
    if (en2 && v1) begin
      ip_len2  <= ip_len1;
      udp_len2 <= udp_len1;
      sum2     <= cfg_sum + {{(udp_hb_pkg::SUM_W-16){1'b0}}, ip_len1};
    end
  end

  // Fold the end-around carries twice; the second fold cannot carry again.
  assign fold1 = {1'b0, sum2[15:0]} + {14'b0, sum2[udp_hb_pkg::SUM_W-1:16]};
  assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

  assign push_valid           = v2;
  assign push_data.ip_length  = ip_len2;
  assign push_data.udp_length = udp_len2;
  assign push_data.checksum   = ~fold2;

endmodule

[rtl/udp_hb_fifo.sv]
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder request queue
// Short queue that decouples the front end from the serialiser.
// ----------------------------------------------------------------------------
module udp_hb_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  udp_hb_pkg::hdr_info_t push_data,
  output logic                  head_valid,
  input  logic                  pop,
  output udp_hb_pkg::hdr_info_t head_data
);

  udp_hb_pkg::hdr_info_t                 mem [udp_hb_pkg::FIFO_DEPTH];
  logic [udp_hb_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [udp_hb_pkg::FIFO_PTR_W-1:0]     rd_ptr;
  logic [udp_hb_pkg::FIFO_CNT_W-1:0]     count;
  logic                                  do_push;
  logic                                  do_pop;

  assign push_ready = count != udp_hb_pkg::FIFO_CNT_W'(udp_hb_pkg::FIFO_DEPTH);
  assign head_valid = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= udp_hb_pkg::FIFO_CNT_W'(udp_hb_pkg::FIFO_DEPTH))
    else $error("queue occupancy beyond depth");
`endif

endmodule

[rtl/udp_hb_back.sv]
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder serialiser
// Walks the 21 header halfwords of the request at the queue head.
// ----------------------------------------------------------------------------
module udp_hb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  udp_hb_pkg::cfg_t            cfg,
  input  logic                        head_valid,
  input  udp_hb_pkg::hdr_info_t       head_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 header_halfword,
  output logic [udp_hb_pkg::IDX_W-1:0] halfword_index,
  output logic                        is_last
);

  logic [udp_hb_pkg::IDX_W-1:0] cnt;
  logic                         out_en;
  logic                         at_last;
  logic [15:0]                  hw_sel;

  assign out_en  = !out_valid || out_ready;
  assign at_last = cnt == udp_hb_pkg::LAST_INDEX;
  assign pop     = out_en && head_valid && at_last;

  always_comb begin
    case (cnt)
      5'd0:    hw_sel = cfg.dest_mac[47:32];
      5'd1:    hw_sel = cfg.dest_mac[31:16];
      5'd2:    hw_sel = cfg.dest_mac[15:0];
      5'd3:    hw_sel = cfg.source_mac[47:32];
      5'd4:    hw_sel = cfg.source_mac[31:16];
      5'd5:    hw_sel = cfg.source_mac[15:0];
      5'd6:    hw_sel = udp_hb_pkg::ETHERTYPE_IPV4;
      5'd7:    hw_sel = udp_hb_pkg::IP_VER_IHL_TOS;
      5'd8:    hw_sel = head_data.ip_length;
      5'd11:   hw_sel = udp_hb_pkg::IP_TTL_PROTO;
      5'd12:   hw_sel = head_data.checksum;
      5'd13:   hw_sel = cfg.source_ip[31:16];
      5'd14:   hw_sel = cfg.source_ip[15:0];
      5'd15:   hw_sel = cfg.dest_ip[31:16];
      5'd16:   hw_sel = cfg.dest_ip[15:0];
      5'd17:   hw_sel = cfg.source_port;
      5'd18:   hw_sel = cfg.dest_port;
      5'd19:   hw_sel = head_data.udp_length;
      default: hw_sel = 16'h0000;  // id, fragment and UDP checksum
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (out_en) begin
      out_valid <= head_valid;
      if (head_valid) begin
        cnt <= at_last ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && head_valid) begin
      header_halfword <= hw_sel;
      halfword_index  <= cnt;
      is_last         <= at_last;
    end
  end

`ifndef SYNTH
  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_last == (halfword_index == udp_hb_pkg::LAST_INDEX)))
    else $error("last flag disagrees with index");

  a_index_advances: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !is_last |=>
      out_valid && (halfword_index == $past(halfword_index) + 1'b1))
    else $error("halfword skipped or header cut short");

  a_restart_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && is_last |=> !out_valid || (halfword_index == '0))
    else $error("new header does not start at halfword 0");
`endif

endmodule

[rtl/udp_ipv4_header_builder.sv]
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder
// Builds the 42-byte Ethernet/IPv4/UDP header for each send request.
// ----------------------------------------------------------------------------
// Usage:
//   Set the MACs, IP addresses and ports through the cfg channel while no
//   request is in flight; cfg_ready is always high and indexes 6 and 7 are
//   dropped. Each word on the input channel is a UDP payload length.
//   For each request the output channel carries 21 halfwords, index 0 to 20,
//   first transmitted byte in the upper half, is_last set on index 20.
// Timing:
//   A request passes the two front-end stages and the queue, then its first
//   halfword is registered. Output runs at one halfword a cycle while
//   out_ready is high, headers back to back; the serialiser sets the rate.
//   The front end (two stages) and a two-entry queue keep taking requests
//   while the serialiser works, so up to four requests can be held.
// Reset and stall:
//   Reset clears the configuration registers to zero and empties the
//   pipeline. When the receiver holds out_ready low the output word holds
//   and the front end fills up, then in_ready falls.
// ----------------------------------------------------------------------------
module udp_ipv4_header_builder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [udp_hb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [udp_hb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       payload_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       header_halfword,
  output logic [udp_hb_pkg::IDX_W-1:0]      halfword_index,
  output logic                              is_last
);

  udp_hb_pkg::cfg_t            cfg;
  logic [udp_hb_pkg::SUM_W-1:0] cfg_sum;
  logic                        push_valid;
  logic                        push_ready;
  udp_hb_pkg::hdr_info_t       push_data;
  logic                        head_valid;
  udp_hb_pkg::hdr_info_t       head_data;
  logic                        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        udp_hb_pkg::REG_DEST_MAC:    cfg.dest_mac    <= cfg_data;
        udp_hb_pkg::REG_SOURCE_MAC:  cfg.source_mac  <= cfg_data;
        udp_hb_pkg::REG_SOURCE_IP:   cfg.source_ip   <= cfg_data[31:0];
        udp_hb_pkg::REG_DEST_IP:     cfg.dest_ip     <= cfg_data[31:0];
        udp_hb_pkg::REG_SOURCE_PORT: cfg.source_port <= cfg_data[15:0];
        udp_hb_pkg::REG_DEST_PORT:   cfg.dest_port   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Fixed part of the IPv4 header sum; only the total length varies per word.
  always_ff @(posedge clk) begin
    cfg_sum <= {3'b0, udp_hb_pkg::IP_VER_IHL_TOS} + {3'b0, udp_hb_pkg::IP_TTL_PROTO}
             + {3'b0, cfg.source_ip[31:16]} + {3'b0, cfg.source_ip[15:0]}
             + {3'b0, cfg.dest_ip[31:16]} + {3'b0, cfg.dest_ip[15:0]};
  end

  udp_hb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .payload_length (payload_length),
    .cfg_sum        (cfg_sum),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  udp_hb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  udp_hb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head_valid      (head_valid),
    .head_data       (head_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .header_halfword (header_halfword),
    .halfword_index  (halfword_index),
    .is_last         (is_last)
  );

endmodule

[bench/tb_udp_ipv4_header_builder.sv]
// ----------------------------------------------------------------------------
// UDP/IPv4 header builder testbench
// Sends payload lengths under several register settings and idle patterns.
// Each request is turned into its 21-halfword header and every output word is
// checked in order against it, including the IPv4 header checksum.
// ----------------------------------------------------------------------------
module tb_udp_ipv4_header_builder;

  typedef logic [udp_hb_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [udp_hb_pkg::CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [udp_hb_pkg::IDX_W-1:0]      hw_idx_t;

  localparam cfg_idx_t REG_SPARE_6 = 3'd6;
  localparam cfg_idx_t REG_SPARE_7 = 3'd7;

  localparam logic [15:0] K_ETHERTYPE    = 16'h0800;
  localparam logic [15:0] K_VER_IHL_TOS  = 16'h4500;
  localparam logic [15:0] K_TTL_PROTO    = {8'd64, 8'd17};
  localparam logic [15:0] K_IP_UDP_BYTES = 16'd28;
  localparam logic [15:0] K_UDP_BYTES    = 16'd8;
  localparam logic [15:0] K_MAX_PAYLOAD  = 16'd65507;

  localparam cfg_data_t ALL_ONES = '1;
  localparam cfg_data_t ALL_ZERO = '0;

  typedef logic [15:0] header_t [udp_hb_pkg::HW_COUNT];

  typedef struct {
    logic [15:0] word;
    hw_idx_t     index;
    logic        last;
  } header_word_t;

  class header_tracker;
    udp_hb_pkg::cfg_t regs;
    header_word_t     words_due[$];
    int unsigned      bad_words;

    function new();
      regs      = '0;
      bad_words = 0;
    endfunction

    // Keep only the low bits each register holds; spare indexes are dropped.
    function void write_register(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        udp_hb_pkg::REG_DEST_MAC:    regs.dest_mac    = data;
        udp_hb_pkg::REG_SOURCE_MAC:  regs.source_mac  = data;
        udp_hb_pkg::REG_SOURCE_IP:   regs.source_ip   = data[31:0];
        udp_hb_pkg::REG_DEST_IP:     regs.dest_ip     = data[31:0];
        udp_hb_pkg::REG_SOURCE_PORT: regs.source_port = data[15:0];
        udp_hb_pkg::REG_DEST_PORT:   regs.dest_port   = data[15:0];
        default: ;
      endcase
    endfunction

    function header_t build_header(logic [15:0] len);
      header_t     hw;
      logic [31:0] acc;
      hw[0]  = regs.dest_mac[47:32];
      hw[1]  = regs.dest_mac[31:16];
      hw[2]  = regs.dest_mac[15:0];
      hw[3]  = regs.source_mac[47:32];
      hw[4]  = regs.source_mac[31:16];
      hw[5]  = regs.source_mac[15:0];
      hw[6]  = K_ETHERTYPE;
      hw[7]  = K_VER_IHL_TOS;
      hw[8]  = len + K_IP_UDP_BYTES;  // wraps at 16 bits for oversized payloads
      hw[9]  = '0;
      hw[10] = '0;
      hw[11] = K_TTL_PROTO;
      hw[12] = '0;
      hw[13] = regs.source_ip[31:16];
      hw[14] = regs.source_ip[15:0];
      hw[15] = regs.dest_ip[31:16];
      hw[16] = regs.dest_ip[15:0];
      hw[17] = regs.source_port;
      hw[18] = regs.dest_port;
      hw[19] = len + K_UDP_BYTES;
      hw[20] = '0;
      // ones-complement sum over the IPv4 header, checksum field still zero
      acc = '0;
      for (int i = 7; i <= 16; i++) acc += hw[i];
      while (acc[31:16] != 0) acc = acc[31:16] + acc[15:0];
      hw[12] = ~acc[15:0];
      return hw;
    endfunction

    function void note_request(logic [15:0] len);
      header_t hw;
      hw = build_header(len);
      for (int k = 0; k < udp_hb_pkg::HW_COUNT; k++)
        words_due.push_back('{word: hw[k], index: hw_idx_t'(k),
                              last: (k == udp_hb_pkg::HW_COUNT - 1)});
    endfunction

    function void check_word(logic [15:0] word, hw_idx_t index, logic last);
      header_word_t want;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected halfword %h index %0d last %b", $time, word, index, last);
        bad_words++;
        return;
      end
      want = words_due.pop_front();
      if (word !== want.word || index !== want.index || last !== want.last) begin
        $display("%0t: mismatch expected %h/%0d/%b got %h/%0d/%b", $time,
                 want.word, want.index, want.last, word, index, last);
        bad_words++;
      end
    endfunction

    function int due_count();
      return words_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  cfg_data_t   cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] payload_length;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] header_halfword;
  hw_idx_t     halfword_index;
  logic        is_last;

  header_tracker tracker = new();
  int            idle_pct    = 0;
  int            stall_pct   = 0;
  logic          hold_off_go = 1'b0;

  udp_ipv4_header_builder DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .payload_length  (payload_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .header_halfword (header_halfword),
    .halfword_index  (halfword_index),
    .is_last         (is_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once asked for.
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_word(header_halfword, halfword_index, is_last);
  end

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
  endtask

  task automatic randomise_registers();
    cfg_write(udp_hb_pkg::REG_DEST_MAC,    cfg_data_t'({$urandom, $urandom}));
    cfg_write(udp_hb_pkg::REG_SOURCE_MAC,  cfg_data_t'({$urandom, $urandom}));
    cfg_write(udp_hb_pkg::REG_SOURCE_IP,   cfg_data_t'({$urandom, $urandom}));
    cfg_write(udp_hb_pkg::REG_DEST_IP,     cfg_data_t'({$urandom, $urandom}));
    cfg_write(udp_hb_pkg::REG_SOURCE_PORT, cfg_data_t'({$urandom, $urandom}));
    cfg_write(udp_hb_pkg::REG_DEST_PORT,   cfg_data_t'({$urandom, $urandom}));
    if ($urandom_range(1))
      cfg_write($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7,
                cfg_data_t'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_length(input logic [15:0] len);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    payload_length <= len;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(len);
  endtask

  // Drop valid, wait for every header word, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] random_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return 16'($urandom_range(1500));
    if (pick < 30) return 16'($urandom_range(65535, 65508));
    return 16'($urandom_range(K_MAX_PAYLOAD));
  endfunction

  initial begin
    logic [15:0] reset_lens [3];
    logic [15:0] ones_lens  [10];
    logic [15:0] mixed_lens [4];
    int          send_idle  [4];
    int          recv_stall [4];

    // zero IPs and this length make the header sum exactly 0xFFFF
    reset_lens = '{16'd0, 16'hFFFF, 16'h7AD2};
    // 16'h7AD4 with all-ones addresses needs a second carry fold
    ones_lens  = '{16'd0, 16'd1, K_MAX_PAYLOAD, 16'd65508, 16'hFFFF,
                   16'h7AD4, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF};
    mixed_lens = '{16'd18, 16'd1472, 16'd65479, 16'h0100};
    send_idle  = '{0, 80, 0, 22};
    recv_stall = '{0, 0, 80, 22};

    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    payload_length = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (reset_lens[i]) send_length(reset_lens[i]);
    drain();

    cfg_write(udp_hb_pkg::REG_DEST_MAC,    ALL_ONES);
    cfg_write(udp_hb_pkg::REG_SOURCE_MAC,  ALL_ONES);
    cfg_write(udp_hb_pkg::REG_SOURCE_IP,   ALL_ONES);
    cfg_write(udp_hb_pkg::REG_DEST_IP,     ALL_ONES);
    cfg_write(udp_hb_pkg::REG_SOURCE_PORT, ALL_ONES);
    cfg_write(udp_hb_pkg::REG_DEST_PORT,   ALL_ONES);
    cfg_write(REG_SPARE_6,                 ALL_ZERO);
    cfg_write(REG_SPARE_7,                 ALL_ZERO);
    cfg_valid <= 1'b0;
    foreach (ones_lens[i]) send_length(ones_lens[i]);
    drain();

    cfg_write(udp_hb_pkg::REG_DEST_MAC,  ALL_ZERO);
    cfg_write(udp_hb_pkg::REG_SOURCE_IP, ALL_ZERO);
    cfg_write(udp_hb_pkg::REG_DEST_PORT, ALL_ZERO);
    cfg_write(REG_SPARE_7,               48'h5A5A_A5A5_0FF0);
    cfg_valid <= 1'b0;
    foreach (mixed_lens[i]) send_length(mixed_lens[i]);
    drain();

    for (int p = 0; p < 4; p++) begin
      randomise_registers();
      idle_pct = send_idle[p];
      stall_pct <= recv_stall[p];
      repeat (21) send_length(random_length());
      drain();
    end

    // hold the receiver off while requests keep coming, so the input stalls
    randomise_registers();
    idle_pct = 0;
    stall_pct <= 0;
    hold_off_go <= 1'b1;
    repeat (8) send_length(random_length());
    drain();

    if (tracker.bad_words == 0 && tracker.due_count() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
